// ===== sv/dnd_pkg.sv =====
// Shared types and constants of the DNS name decompressor.
`default_nettype none
package dnd_pkg;

	localparam int NAME_MAX_BYTES_DEF = 256;
	localparam int PACKET_BYTES_DEF   = 512;

	// Read position: a 14-bit pointer target plus headroom for label advances.
	localparam int POS_W = 15;
	// Width of name length and consumed count sums.
	localparam int SUM_W = 10;

	localparam logic [7:0] PTR_MARK        = 8'hC0;
	localparam logic [7:0] DOT_CHAR        = 8'h2E;
	localparam logic [3:0] CHUNK_CHARS     = 4'd8;
	localparam logic [7:0] MAX_STEPS_RESET = 8'd64;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEN_RD,
		S_LEN_CHK,
		S_PTR_RD,
		S_PTR_CHK,
		S_CHR_RD,
		S_CHR_WR,
		S_DOT,
		S_EM_START,
		S_EM_RD,
		S_EM_ACC,
		S_EM_SEND
	} seq_state_t;

endpackage
`default_nettype wire

// ===== sv/dnd_if.sv =====
// Valid/ready channel interfaces for items, results and configuration.
`default_nettype none
interface dnd_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [8:0] load_address;
	logic [7:0] load_byte;
	logic [8:0] start_offset;

	modport source (output valid, action, load_address, load_byte, start_offset,
		input ready);
	modport sink (input valid, action, load_address, load_byte, start_offset,
		output ready);
endinterface

interface dnd_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] name_chunk;
	logic [3:0]  chunk_bytes;
	logic        last;
	logic [1:0]  status;
	logic [8:0]  consumed_bytes;

	modport source (output valid, name_chunk, chunk_bytes, last, status, consumed_bytes,
		input ready);
	modport sink (input valid, name_chunk, chunk_bytes, last, status, consumed_bytes,
		output ready);
endinterface

interface dnd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/dnd_pkt_store.sv =====
// Packet byte store: one write port, one registered read port.
`default_nettype none
module dnd_pkt_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/dnd_name_store.sv =====
// Decoded name store: one write port, one registered read port.
`default_nettype none
module dnd_name_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/dnd_walk_seq.sv =====
// Label walk and chunk emission sequencer around one shared address adder.
`default_nettype none
module dnd_walk_seq #(
	parameter int NAME_MAX_BYTES = dnd_pkg::NAME_MAX_BYTES_DEF,
	parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
	parameter int PA_W           = $clog2(PACKET_BYTES),
	parameter int NA_W           = $clog2(NAME_MAX_BYTES)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      max_steps,
	dnd_item_if.sink             item,
	dnd_result_if.source         result,
	output logic                 pkt_we,
	output logic      [PA_W-1:0] pkt_waddr,
	output logic      [7:0]      pkt_wdata,
	output logic                 pkt_re,
	output logic      [PA_W-1:0] pkt_raddr,
	input  wire logic [7:0]      pkt_rdata,
	output logic                 nm_we,
	output logic      [NA_W-1:0] nm_waddr,
	output logic      [7:0]      nm_wdata,
	output logic                 nm_re,
	output logic      [NA_W-1:0] nm_raddr,
	input  wire logic [7:0]      nm_rdata
);
	import dnd_pkg::*;

	localparam int NL_W = $clog2(NAME_MAX_BYTES + 1);

	seq_state_t state_q, state_d;

	logic [POS_W-1:0] pos_q;
	logic [8:0]       off_q;
	logic [7:0]       len_q;
	logic [5:0]       hi_q;
	logic [NL_W-1:0]  nl_q;
	logic [SUM_W-1:0] cc_q;
	logic             jmp_q;
	logic [7:0]       steps_q;
	status_t          st_q;
	logic [NL_W-1:0]  rem_q;
	logic [NL_W-1:0]  rp_q;
	logic [3:0]       cnt_q;
	logic [2:0]       k_q;
	logic [63:0]      word_q;

	logic             out_vld_q;
	logic [63:0]      chunk_q;
	logic [3:0]       bytes_q;
	logic             last_q;
	logic [1:0]       status_q;
	logic [8:0]       consumed_q;

	logic             acc;
	logic [POS_W-1:0] sum;
	logic             oob;
	logic             is_ptr;
	logic             walk_done;
	logic             too_long;
	logic [SUM_W-1:0] need;
	logic [NL_W-1:0]  chars;
	logic [3:0]       cnt_nx;
	logic             is_last;
	logic             load_out;
	logic             load_ok;

	// Shared address adder: every packet read goes through it.
	assign sum = pos_q + POS_W'(off_q);
	assign oob = (sum >= POS_W'(PACKET_BYTES));

	assign acc     = item.valid && item.ready;
	assign load_ok = (POS_W'(item.load_address) < POS_W'(PACKET_BYTES));
	assign is_ptr  = ((pkt_rdata & PTR_MARK) == PTR_MARK);
	assign walk_done = (pkt_rdata == 8'd0) || (cc_q >= SUM_W'(NAME_MAX_BYTES))
		|| (steps_q >= max_steps);
	assign need     = SUM_W'(nl_q) + SUM_W'(pkt_rdata) + SUM_W'(1);
	assign too_long = (need >= SUM_W'(NAME_MAX_BYTES));
	assign chars    = (nl_q == '0) ? '0 : nl_q - NL_W'(1);
	assign cnt_nx   = (rem_q > NL_W'(CHUNK_CHARS)) ? CHUNK_CHARS : 4'(rem_q);
	assign is_last  = (rem_q == NL_W'(cnt_q));
	assign load_out = (state_q == S_EM_SEND) && (!out_vld_q || result.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && item.action == ACT_DECODE) state_d = S_LEN_RD;
			end
			S_LEN_RD: state_d = oob ? S_EM_SEND : S_LEN_CHK;
			S_LEN_CHK: begin
				if (walk_done) state_d = S_EM_START;
				else if (is_ptr) state_d = S_PTR_RD;
				else if (too_long) state_d = S_EM_SEND;
				else state_d = S_CHR_RD;
			end
			S_PTR_RD: state_d = oob ? S_EM_SEND : S_PTR_CHK;
			S_PTR_CHK: state_d = S_LEN_RD;
			S_CHR_RD: state_d = oob ? S_EM_SEND : S_CHR_WR;
			S_CHR_WR: state_d = (off_q == {1'b0, len_q}) ? S_DOT : S_CHR_RD;
			S_DOT: state_d = S_LEN_RD;
			S_EM_START: state_d = (cnt_nx == 4'd0) ? S_EM_SEND : S_EM_RD;
			S_EM_RD: state_d = S_EM_ACC;
			S_EM_ACC: state_d = ({1'b0, k_q} + 4'd1 == cnt_q) ? S_EM_SEND : S_EM_RD;
			S_EM_SEND: begin
				if (load_out) state_d = is_last ? S_IDLE : S_EM_START;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item.ready = (state_q == S_IDLE);
		pkt_we     = (state_q == S_IDLE) && acc && (item.action == ACT_LOAD) && load_ok;
		pkt_waddr  = PA_W'(item.load_address);
		pkt_wdata  = item.load_byte;
		pkt_re     = ((state_q == S_LEN_RD) || (state_q == S_PTR_RD)
			|| (state_q == S_CHR_RD)) && !oob;
		pkt_raddr  = PA_W'(sum);
		nm_we      = (state_q == S_CHR_WR) || (state_q == S_DOT);
		nm_waddr   = nl_q[NA_W-1:0];
		nm_wdata   = (state_q == S_DOT) ? DOT_CHAR : pkt_rdata;
		nm_re      = (state_q == S_EM_RD);
		nm_raddr   = rp_q[NA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_vld_q <= 1'b1;
			else if (result.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc && item.action == ACT_DECODE) begin
					pos_q   <= POS_W'(item.start_offset);
					off_q   <= '0;
					nl_q    <= '0;
					cc_q    <= '0;
					jmp_q   <= 1'b0;
					steps_q <= '0;
					st_q    <= ST_OK;
				end
			end
			S_LEN_RD, S_PTR_RD, S_CHR_RD: begin
				if (oob) begin
					st_q   <= ST_RANGE;
					word_q <= '0;
					cnt_q  <= '0;
					rem_q  <= '0;
				end
			end
			S_LEN_CHK: begin
				if (walk_done) begin
					if (!jmp_q) cc_q <= cc_q + SUM_W'(1);
					rem_q <= chars;
					rp_q  <= '0;
				end else if (is_ptr) begin
					hi_q  <= pkt_rdata[5:0];
					off_q <= 9'd1;
				end else if (too_long) begin
					st_q   <= ST_TOO_LONG;
					word_q <= '0;
					cnt_q  <= '0;
					rem_q  <= '0;
				end else begin
					len_q <= pkt_rdata;
					off_q <= 9'd1;
				end
			end
			S_PTR_CHK: begin
				pos_q <= POS_W'({hi_q, pkt_rdata});
				if (!jmp_q) cc_q <= cc_q + SUM_W'(2);
				jmp_q   <= 1'b1;
				steps_q <= steps_q + 8'd1;
				off_q   <= '0;
			end
			S_CHR_WR: begin
				nl_q  <= nl_q + NL_W'(1);
				off_q <= off_q + 9'd1;
			end
			S_DOT: begin
				// Here off_q is the label length plus one.
				nl_q    <= nl_q + NL_W'(1);
				pos_q   <= sum;
				if (!jmp_q) cc_q <= cc_q + SUM_W'(off_q);
				steps_q <= steps_q + 8'd1;
				off_q   <= '0;
			end
			S_EM_START: begin
				cnt_q  <= cnt_nx;
				k_q    <= '0;
				word_q <= '0;
			end
			S_EM_ACC: begin
				word_q[8*k_q +: 8] <= nm_rdata;
				k_q  <= k_q + 3'd1;
				rp_q <= rp_q + NL_W'(1);
			end
			S_EM_SEND: begin
				if (load_out) rem_q <= rem_q - NL_W'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			chunk_q    <= word_q;
			bytes_q    <= cnt_q;
			last_q     <= is_last;
			status_q   <= st_q;
			consumed_q <= (is_last && st_q == ST_OK) ? cc_q[8:0] : 9'd0;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.name_chunk     = chunk_q;
	assign result.chunk_bytes    = bytes_q;
	assign result.last           = last_q;
	assign result.status         = status_q;
	assign result.consumed_bytes = consumed_q;
endmodule
`default_nettype wire

// ===== sv/dns_name_decompressor_unit.sv =====
// Top level of the DNS name decompressor: stores, sequencer and step limit register.
//
//   channel  dir  beat carries
//   item     in   action, load_address, load_byte, start_offset
//   result   out  name_chunk, chunk_bytes, last, status, consumed_bytes
//   cfg      in   data = max_steps
//
// A decode beat walks the packet store, reading each byte and then checking it, or
// writing it to the name store if it is a name character; a pointer adds a second read
// and check, and each label a dot write. Emission then reads each chunk from the name store
// and sends it. The walk is bounded by the single packet store read port and the shared adder.
// item.ready is low from decode start until the last result beat is registered.
// A full output register stalls the sequencer; arst_n clears the control state only.
`default_nettype none
module dns_name_decompressor_unit #(
	parameter int NAME_MAX_BYTES = dnd_pkg::NAME_MAX_BYTES_DEF,
	parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	dnd_item_if.sink     item,
	dnd_result_if.source result,
	dnd_cfg_if.sink      cfg
);
	import dnd_pkg::*;

	localparam int PA_W = $clog2(PACKET_BYTES);
	localparam int NA_W = $clog2(NAME_MAX_BYTES);

	logic [7:0]      max_steps_q;
	logic            pkt_we;
	logic [PA_W-1:0] pkt_waddr;
	logic [7:0]      pkt_wdata;
	logic            pkt_re;
	logic [PA_W-1:0] pkt_raddr;
	logic [7:0]      pkt_rdata;
	logic            nm_we;
	logic [NA_W-1:0] nm_waddr;
	logic [7:0]      nm_wdata;
	logic            nm_re;
	logic [NA_W-1:0] nm_raddr;
	logic [7:0]      nm_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= MAX_STEPS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			max_steps_q <= cfg.data;
		end
	end

	dnd_pkt_store #(
		.DEPTH (PACKET_BYTES),
		.AW    (PA_W)
	) u_pkt_store (
		.clk   (clk),
		.we    (pkt_we),
		.waddr (pkt_waddr),
		.wdata (pkt_wdata),
		.re    (pkt_re),
		.raddr (pkt_raddr),
		.rdata (pkt_rdata)
	);

	dnd_name_store #(
		.DEPTH (NAME_MAX_BYTES),
		.AW    (NA_W)
	) u_name_store (
		.clk   (clk),
		.we    (nm_we),
		.waddr (nm_waddr),
		.wdata (nm_wdata),
		.re    (nm_re),
		.raddr (nm_raddr),
		.rdata (nm_rdata)
	);

	dnd_walk_seq #(
		.NAME_MAX_BYTES (NAME_MAX_BYTES),
		.PACKET_BYTES   (PACKET_BYTES),
		.PA_W           (PA_W),
		.NA_W           (NA_W)
	) u_walk_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_steps (max_steps_q),
		.item      (item),
		.result    (result),
		.pkt_we    (pkt_we),
		.pkt_waddr (pkt_waddr),
		.pkt_wdata (pkt_wdata),
		.pkt_re    (pkt_re),
		.pkt_raddr (pkt_raddr),
		.pkt_rdata (pkt_rdata),
		.nm_we     (nm_we),
		.nm_waddr  (nm_waddr),
		.nm_wdata  (nm_wdata),
		.nm_re     (nm_re),
		.nm_raddr  (nm_raddr),
		.nm_rdata  (nm_rdata)
	);
endmodule
`default_nettype wire

// ===== bench/dnd_name_checker.sv =====
// Watches the item, result and step limit channels, predicts each decoded name and checks it.
`timescale 1ns / 100ps
module dnd_name_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	dnd_item_if       item,
	dnd_result_if     result,
	dnd_cfg_if        cfg,
	output int        fail_count,
	output int        pending
);
	import dnd_pkg::*;

	localparam int STORE_BYTES = PACKET_BYTES_DEF;
	localparam int NAME_BYTES  = NAME_MAX_BYTES_DEF;
	localparam int CHUNK       = CHUNK_CHARS;

	typedef struct packed {
		logic [63:0] chunk;
		logic [3:0]  nbytes;
		logic        last;
		status_t     status;
		logic [8:0]  consumed;
	} name_beat_t;

	logic [7:0] packet_copy [STORE_BYTES];
	logic [7:0] step_limit = MAX_STEPS_RESET;
	name_beat_t expected_beats [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t name_check: %s", $time, msg);
		fail_count++;
	endtask

	// Walks the mirrored packet store from the start offset and queues the beats of the name.
	task automatic predict_name(input logic [8:0] start);
		logic [7:0] name_buf [NAME_BYTES];
		name_beat_t beat;
		status_t    err;
		int         pos, nlen, used, steps, len, chars, nchunks, cnt, taken, k, i;
		bit         jumped, done;
		pos = start;
		nlen = 0;
		used = 0;
		steps = 0;
		jumped = 1'b0;
		done = 1'b0;
		err = ST_OK;
		while (!done) begin
			if (pos >= STORE_BYTES) begin
				err = ST_RANGE;
				done = 1'b1;
			end else if (packet_copy[pos] == 8'h00 || used >= NAME_BYTES
					|| steps >= step_limit) begin
				done = 1'b1;
			end else if ((packet_copy[pos] & PTR_MARK) == PTR_MARK) begin
				if (pos + 1 >= STORE_BYTES) begin
					err = ST_RANGE;
					done = 1'b1;
				end else begin
					// Only the first jump counts toward the bytes consumed at the start offset.
					if (!jumped)
						used += 2;
					jumped = 1'b1;
					pos = {packet_copy[pos][5:0], packet_copy[pos + 1]};
					steps++;
				end
			end else begin
				len = packet_copy[pos];
				if (nlen + len + 1 >= NAME_BYTES) begin
					err = ST_TOO_LONG;
					done = 1'b1;
				end else if (pos + len >= STORE_BYTES) begin
					err = ST_RANGE;
					done = 1'b1;
				end else begin
					for (i = 0; i < len; i++)
						name_buf[nlen + i] = packet_copy[pos + 1 + i];
					nlen += len;
					name_buf[nlen] = DOT_CHAR;
					nlen++;
					if (!jumped)
						used += len + 1;
					pos += len + 1;
					steps++;
				end
			end
		end

		if (err != ST_OK) begin
			beat = '0;
			beat.last = 1'b1;
			beat.status = err;
			expected_beats.push_back(beat);
		end else begin
			if (!jumped)
				used++;
			// The trailing dot is never sent.
			chars = (nlen > 0) ? nlen - 1 : 0;
			nchunks = (chars + CHUNK - 1) / CHUNK;
			if (nchunks == 0)
				nchunks = 1;
			taken = 0;
			for (k = 0; k < nchunks; k++) begin
				cnt = chars - taken;
				if (cnt > CHUNK)
					cnt = CHUNK;
				beat = '0;
				for (i = 0; i < cnt; i++)
					beat.chunk[8 * i +: 8] = name_buf[taken + i];
				taken += cnt;
				beat.nbytes = 4'(cnt);
				beat.last = (k == nchunks - 1);
				beat.status = ST_OK;
				beat.consumed = (k == nchunks - 1) ? 9'(used) : 9'd0;
				expected_beats.push_back(beat);
			end
		end
	endtask

	always @(posedge clk) begin : monitor
		name_beat_t want;
		if (!arst_n) begin
			step_limit = MAX_STEPS_RESET;
		end else begin
			if (cfg.valid && cfg.ready)
				step_limit = cfg.data;
			if (result.valid && result.ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing expected, chunk %h",
						result.name_chunk));
				end else begin
					want = expected_beats.pop_front();
					if (result.name_chunk !== want.chunk)
						report_mismatch($sformatf("name_chunk %h, expected %h",
							result.name_chunk, want.chunk));
					if (result.chunk_bytes !== want.nbytes)
						report_mismatch($sformatf("chunk_bytes %0d, expected %0d",
							result.chunk_bytes, want.nbytes));
					if (result.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b", result.last, want.last));
					if (result.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							result.status, want.status));
					if (result.consumed_bytes !== want.consumed)
						report_mismatch($sformatf("consumed_bytes %0d, expected %0d",
							result.consumed_bytes, want.consumed));
				end
			end
			if (item.valid && item.ready) begin
				if (item.action == ACT_LOAD)
					packet_copy[item.load_address] = item.load_byte;
				else
					predict_name(item.start_offset);
			end
			pending = expected_beats.size();
		end
	end

endmodule

// ===== bench/dns_name_decompressor_unit_tb.sv =====
// Drives packet loads, decodes and step limit writes into the decompressor and gives the verdict.
`timescale 1ns / 100ps
module dns_name_decompressor_unit_tb;
	import dnd_pkg::*;

	localparam int     STORE_BYTES   = PACKET_BYTES_DEF;
	localparam int     PHASE_ITEMS   = 90;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     DRAIN_CYCLES  = 40;
	localparam longint RUN_LIMIT_NS  = 6_400_000;

	logic       clk;
	logic       arst_n;
	int         fail_count;
	int         pending;
	bit         steady;
	bit         hold_request;
	int         phase_items;
	logic [7:0] layout [STORE_BYTES];

	dnd_item_if   item_ch ();
	dnd_result_if result_ch ();
	dnd_cfg_if    cfg_ch ();

	dns_name_decompressor_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	dnd_name_checker name_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("dns_name_decompressor_unit_tb: FAIL");
		$finish;
	end

	initial begin : result_sink
		int i;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				// Hold long enough for the output side to back up into the item channel.
				for (i = 0; i < HOLD_CYCLES; i++) begin
					result_ch.ready <= 1'b0;
					@(negedge clk);
				end
			end
			result_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
		end
	end

	task automatic put_item(input logic act, input logic [8:0] addr, input logic [7:0] value,
			input logic [8:0] start);
		while (!steady && $urandom_range(0, 99) < 33) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.load_address <= addr;
		item_ch.load_byte <= value;
		item_ch.start_offset <= start;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		phase_items++;
	endtask

	// Bytes that would fall past the store are simply not written.
	task automatic load_byte(input int addr, input logic [7:0] value);
		if (addr < STORE_BYTES)
			put_item(ACT_LOAD, 9'(addr), value, 9'($urandom));
	endtask

	task automatic decode_at(input logic [8:0] start);
		put_item(ACT_DECODE, 9'($urandom), 8'($urandom), start);
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_step_limit(input logic [7:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic place_label(inout int at, input string text);
		int i;
		layout[at] = 8'(text.len());
		for (i = 0; i < text.len(); i++)
			layout[at + 1 + i] = text[i];
		at += text.len() + 1;
	endtask

	// Writes a fresh name somewhere in the store and decodes it, now and then also a random offset.
	task automatic name_scene();
		int         at, base, labels, len, i, j, pick;
		logic [8:0] target;
		base = $urandom_range(0, STORE_BYTES - 1);
		at = base;
		labels = $urandom_range(0, 4);
		for (i = 0; i < labels; i++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 63) : $urandom_range(1, 10);
			load_byte(at, 8'(len));
			at++;
			for (j = 0; j < len; j++) begin
				load_byte(at, ($urandom_range(0, 3) == 0) ? 8'($urandom)
					: 8'($urandom_range(97, 122)));
				at++;
			end
		end
		pick = $urandom_range(0, 9);
		target = 9'($urandom);
		if (pick < 6) begin
			load_byte(at, 8'h00);
		end else if (pick < 9) begin
			load_byte(at, PTR_MARK | {7'd0, target[8]});
			load_byte(at + 1, target[7:0]);
		end else begin
			// A pointer whose target lies past the end of the store.
			load_byte(at, PTR_MARK | 8'($urandom_range(2, 63)));
			load_byte(at + 1, target[7:0]);
		end
		decode_at(9'(base));
		if ($urandom_range(0, 3) == 0)
			decode_at(9'($urandom));
	endtask

	task automatic random_phase(input logic [7:0] limit, input bit with_hold, input bit calm);
		set_step_limit(limit);
		steady = calm;
		hold_request = with_hold;
		phase_items = 0;
		while (phase_items < PHASE_ITEMS) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 4)) load_byte($urandom_range(0, STORE_BYTES - 1),
					8'($urandom));
				decode_at(9'($urandom));
			end else begin
				name_scene();
			end
		end
		steady = 1'b0;
	endtask

	initial begin : stimulus
		int at, i;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_LOAD;
		item_ch.load_address = '0;
		item_ch.load_byte = '0;
		item_ch.start_offset = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		steady = 1'b0;
		hold_request = 1'b0;
		phase_items = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole store so that no walk ever reads an unwritten byte.
		for (i = 0; i < STORE_BYTES; i++) begin
			case ($urandom_range(0, 3))
				0: layout[i] = 8'h00;
				1: layout[i] = 8'($urandom_range(1, 15));
				2: layout[i] = 8'($urandom_range(97, 122));
				default: layout[i] = 8'($urandom);
			endcase
		end
		at = 0;
		place_label(at, "www");
		place_label(at, "example");
		place_label(at, "com");
		layout[at] = 8'h00;
		// Pointer back to the name above, an empty name and a pointer to itself.
		layout[17] = 8'hC0;
		layout[18] = 8'h00;
		layout[19] = 8'h00;
		layout[20] = 8'hC0;
		layout[21] = 8'h14;
		// Two long labels and a jump bring the consumed count to its limit.
		layout[22] = 8'h7F;
		layout[150] = 8'h7D;
		layout[276] = 8'hC0;
		layout[277] = 8'h00;
		// Two labels of 191 characters overflow the name.
		layout[278] = 8'hBF;
		layout[470] = 8'hBF;
		layout[471] = 8'hC2;
		layout[472] = 8'h00;
		// A one-character label followed by a pointer back to it.
		layout[473] = 8'h01;
		layout[474] = 8'h61;
		layout[475] = 8'hC1;
		layout[476] = 8'hD9;
		// A label that runs off the end of the store.
		layout[506] = 8'h08;
		layout[511] = 8'hC0;
		for (i = 0; i < STORE_BYTES; i++)
			load_byte(i, layout[i]);

		decode_at(9'd0);
		decode_at(9'd17);
		decode_at(9'd19);
		decode_at(9'd20);
		decode_at(9'd22);
		decode_at(9'd278);
		decode_at(9'd471);
		decode_at(9'd506);
		decode_at(9'd473);
		load_byte(511, 8'hFF);
		decode_at(9'd511);
		load_byte(0, 8'h00);
		decode_at(9'd0);
		load_byte(0, 8'h03);
		decode_at(9'd0);
		set_step_limit(8'd255);
		decode_at(9'd473);
		decode_at(9'd20);
		decode_at(9'd22);

		random_phase(8'd255, 1'b0, 1'b0);
		random_phase(8'd1, 1'b0, 1'b1);
		random_phase(8'd0, 1'b1, 1'b0);
		random_phase(8'($urandom_range(2, 254)), 1'b0, 1'b0);
		random_phase(8'($urandom_range(1, 255)), 1'b0, 1'b0);

		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("dns_name_decompressor_unit_tb: PASS");
		else
			$display("dns_name_decompressor_unit_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/dnd_pkg.sv
sv/dnd_if.sv
sv/dnd_pkt_store.sv
sv/dnd_name_store.sv
sv/dnd_walk_seq.sv
sv/dns_name_decompressor_unit.sv
bench/dnd_name_checker.sv
bench/dns_name_decompressor_unit_tb.sv
